// ===== hdl/vrd_pkg.sv =====
package vrd_pkg;

  // Fixed widths of the walker
  localparam int MAP_W     = 12;  // signed cell coordinate, covers start cell +/- 1023 steps
  localparam int SIDE_W    = 60;  // side distances and deltas, Q.16
  localparam int DIV_STEPS = 31;  // quotient bits of 2^30 / |dir|
  localparam int HUGE_SH   = 58;  // zero component: delta = 2^58
  localparam int DIST_W    = 25;
  localparam int PROD_W    = 41;  // Q1.14 dir times Q8.16 distance
  localparam int WIDE_W    = 62;

  // Axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Input op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_AX,
    ST_DIV,
    ST_MUL,
    ST_RD,
    ST_TEST,
    ST_DIST,
    ST_PROD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic ld_in;
    logic clr;
    logic rd_wr;
    logic wb;
    logic ax_inc;
    logic div_init;
    logic div_step;
    logic ld_axis;
    logic rd_cast;
    logic step;
    logic set_hit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic clr_last;
    logic wr_in_grid;
    logic ax_last;
    logic mag_zero;
    logic div_last;
    logic bound_hit;
    logic steps_done;
    logic cell_solid;
    logic out_free;
    logic stepped;
  } sts_t;

  // Saturate to signed Q8.16
  function automatic logic [DIST_W-1:0] sat_dist(input logic signed [WIDE_W-1:0] v);
    logic [DIST_W-1:0] r;
    if (v < -62'sd16777216) begin
      r = 25'h1000000;
    end else if (v > 62'sd16777215) begin
      r = 25'h0FFFFFF;
    end else begin
      r = v[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/vrd_in_if.sv =====
interface vrd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [5:0]  voxel_x;
  logic [5:0]  voxel_y;
  logic [5:0]  voxel_z;
  logic        solid;
  logic [21:0] origin_x;
  logic [21:0] origin_y;
  logic [21:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [23:0] max_distance;

  modport source (output valid, op, voxel_x, voxel_y, voxel_z, solid, origin_x, origin_y,
                  origin_z, dir_x, dir_y, dir_z, max_distance, input ready);
  modport sink (input valid, op, voxel_x, voxel_y, voxel_z, solid, origin_x, origin_y,
                origin_z, dir_x, dir_y, dir_z, max_distance, output ready);
endinterface

// ===== hdl/vrd_out_if.sv =====
interface vrd_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [5:0]  hit_voxel_x;
  logic [5:0]  hit_voxel_y;
  logic [5:0]  hit_voxel_z;
  logic signed [24:0] distance;
  logic [1:0]  normal_axis;
  logic        normal_negative;
  logic signed [24:0] point_x;
  logic signed [24:0] point_y;
  logic signed [24:0] point_z;

  modport source (output valid, hit, hit_voxel_x, hit_voxel_y, hit_voxel_z, distance,
                  normal_axis, normal_negative, point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, hit_voxel_x, hit_voxel_y, hit_voxel_z, distance,
                normal_axis, normal_negative, point_x, point_y, point_z, output ready);
endinterface

// ===== hdl/vrd_cfg_if.sv =====
interface vrd_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] step_limit;

  modport source (output valid, step_limit, input ready);
  modport sink (input valid, step_limit, output ready);
endinterface

// ===== hdl/voxel_ray_dda_traversal.sv =====
// Write item: accept, row read, then row write back; a voxel outside the grid is dropped.
// Cast item: a setup step per zero direction component, a reciprocal per other one (shared
// one-bit-a-cycle reciprocal divider), per cell tested a registered occupancy read,
// then test and step, then a finish state, preceded on a hit by distance and product states.
// One item is in work at a time; a finished result waits in the output register.
// Reset: step_limit 500, grid cleared one row a cycle (4096 by default), in ready low.
module voxel_ray_dda_traversal #(
  parameter int GRID_BITS = 6
) (
  input logic       clk,
  input logic       rst_n,
  vrd_in_if.sink    in_ch,
  vrd_out_if.source out_ch,
  vrd_cfg_if.sink   cfg_ch
);
  import vrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vrd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  vrd_dp #(.GRID_BITS(GRID_BITS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

`ifndef SYNTHESIS
  // the cast read never shares a cycle with a memory write
  a_rd_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_cast |-> !cmd.wb && !cmd.clr)
    else $error("cast read during memory write");

  // result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // a step leaves the walk marked as stepped
  a_stepped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> sts.stepped)
    else $error("step not recorded");
`endif
endmodule

// ===== hdl/vrd_ram.sv =====
module vrd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/vrd_ctrl.sv =====
module vrd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  vrd_pkg::sts_t sts,
  output vrd_pkg::cmd_t cmd
);
  import vrd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      // wipe the grid one row a cycle
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = (sts.in_op == OP_CAST) ? ST_AX : ST_WR_RD;
        end
      end
      // read-modify-write of one row
      ST_WR_RD: begin
        if (sts.wr_in_grid) begin
          cmd.rd_wr = 1'b1;
          state_nxt = ST_WR_WB;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WR_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = ST_IDLE;
      end
      // per-axis setup: reciprocal (skipped for a zero component) then first side distance
      ST_AX: begin
        if (sts.mag_zero) begin
          cmd.ld_axis = 1'b1;
          if (sts.ax_last) begin
            state_nxt = ST_RD;
          end else begin
            cmd.ax_inc = 1'b1;
          end
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.ld_axis = 1'b1;
        if (sts.ax_last) begin
          state_nxt = ST_RD;
        end else begin
          cmd.ax_inc = 1'b1;
          state_nxt  = ST_AX;
        end
      end
      // walk loop
      ST_RD: begin
        if (sts.bound_hit || sts.steps_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.rd_cast = 1'b1;
          state_nxt   = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.cell_solid) begin
          cmd.set_hit = 1'b1;
          state_nxt   = ST_DIST;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_DIST: state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/vrd_dp.sv =====
module vrd_dp #(
  parameter int GRID_BITS = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  vrd_in_if.sink        in_ch,
  vrd_out_if.source     out_ch,
  vrd_cfg_if.sink       cfg_ch,
  input  vrd_pkg::cmd_t cmd,
  output vrd_pkg::sts_t sts
);
  import vrd_pkg::*;

  localparam int ROW_W     = 2 * GRID_BITS;
  localparam int ROWS      = 1 << ROW_W;
  localparam int LINE_W    = 1 << GRID_BITS;
  localparam int GRID_SIZE = 1 << GRID_BITS;

  // latched item
  logic [5:0]        vox_r [3];
  logic              solid_r;
  logic [21:0]       org_r [3];
  logic [15:0]       dir_r [3];
  logic [23:0]       maxd_r;

  // walk state
  logic [MAP_W-1:0]  map_r [3];
  logic [SIDE_W-1:0] side_r [3];
  logic [SIDE_W-1:0] delta_r [3];
  logic              neg [3];
  logic [15:0]       mag [3];
  logic [16:0]       frac_n [3];
  logic [1:0]        ax_r;
  logic [1:0]        last_r;
  logic              stepped_r;
  logic              hit_r;
  logic [9:0]        steps_r;
  logic [9:0]        limit_r;
  logic [1:0]        step_ax;
  logic [SIDE_W-1:0] min01, min_all;

  // divider
  logic [30:0]       q_r;
  logic [15:0]       rem_r;
  logic [4:0]        div_cnt_r;
  logic [16:0]       trial;
  logic              ge;
  logic [15:0]       sel_mag;
  logic [16:0]       sel_n;
  logic [47:0]       mul_prod;

  // memory
  logic [ROW_W-1:0]  clr_cnt_r;
  logic [ROW_W-1:0]  vox_row, map_row, waddr, raddr;
  logic [LINE_W-1:0] rdata, wdata, vmask;
  logic              we;
  logic              in_grid_r;
  logic [GRID_BITS-1:0] zsel_r;
  logic              map_in_grid;

  // result math
  logic [SIDE_W-1:0] side_last, delta_last;
  logic              neg_last;
  logic [DIST_W-1:0] dist_r;
  logic signed [PROD_W-1:0] prod_r [3];
  logic [DIST_W-1:0] point [3];

  // output register
  logic              out_valid_r;
  logic              o_hit_r, o_neg_r;
  logic [5:0]        o_vox_r [3];
  logic [DIST_W-1:0] o_dist_r;
  logic [1:0]        o_axis_r;
  logic [DIST_W-1:0] o_pt_r [3];

  // per-axis setup terms
  for (genvar a = 0; a < 3; a++) begin : g_ax
    assign neg[a]    = dir_r[a][15];
    assign mag[a]    = neg[a] ? 16'(~dir_r[a] + 16'd1) : dir_r[a];
    assign frac_n[a] = neg[a] ? {1'b0, org_r[a][15:0]} : 17'(17'h10000 - {1'b0, org_r[a][15:0]});
  end

  always_comb begin
    case (ax_r)
      AX_X:    begin sel_mag = mag[0]; sel_n = frac_n[0]; end
      AX_Y:    begin sel_mag = mag[1]; sel_n = frac_n[1]; end
      default: begin sel_mag = mag[2]; sel_n = frac_n[2]; end
    endcase
  end

  // restoring division of 2^30 by |dir|, one quotient bit a cycle
  assign trial    = {rem_r, (div_cnt_r == 5'd0)};
  assign ge       = trial >= {1'b0, sel_mag};
  assign mul_prod = 48'(q_r) * 48'(sel_n);

  // axis selection, ties go to the later axis
  always_comb begin
    if (side_r[0] < side_r[1]) begin
      step_ax = (side_r[0] < side_r[2]) ? AX_X : AX_Z;
    end else begin
      step_ax = (side_r[1] < side_r[2]) ? AX_Y : AX_Z;
    end
    min01   = (side_r[1] < side_r[0]) ? side_r[1] : side_r[0];
    min_all = (side_r[2] < min01) ? side_r[2] : min01;
  end

  always_comb begin
    case (last_r)
      AX_X:    begin side_last = side_r[0]; delta_last = delta_r[0]; neg_last = neg[0]; end
      AX_Y:    begin side_last = side_r[1]; delta_last = delta_r[1]; neg_last = neg[1]; end
      default: begin side_last = side_r[2]; delta_last = delta_r[2]; neg_last = neg[2]; end
    endcase
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      vox_r[0] <= in_ch.voxel_x;
      vox_r[1] <= in_ch.voxel_y;
      vox_r[2] <= in_ch.voxel_z;
      solid_r  <= in_ch.solid;
      org_r[0] <= in_ch.origin_x;
      org_r[1] <= in_ch.origin_y;
      org_r[2] <= in_ch.origin_z;
      dir_r[0] <= in_ch.dir_x;
      dir_r[1] <= in_ch.dir_y;
      dir_r[2] <= in_ch.dir_z;
      maxd_r   <= in_ch.max_distance;
    end
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q_r       <= '0;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r       <= {q_r[29:0], ge};
      rem_r     <= ge ? 16'(trial - {1'b0, sel_mag}) : trial[15:0];
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // per-axis walk registers
  for (genvar a = 0; a < 3; a++) begin : g_walk
    always_ff @(posedge clk) begin
      if (cmd.ld_in) begin
        map_r[a] <= MAP_W'(in_ch.origin_x[21:16] & 6'h00) | MAP_W'(a == 0 ? in_ch.origin_x[21:16]
                    : (a == 1 ? in_ch.origin_y[21:16] : in_ch.origin_z[21:16]));
      end else if (cmd.step && step_ax == 2'(a)) begin
        map_r[a] <= neg[a] ? map_r[a] - MAP_W'(1) : map_r[a] + MAP_W'(1);
      end
      if (cmd.ld_axis && ax_r == 2'(a)) begin
        if (sel_mag == 16'd0) begin
          delta_r[a] <= SIDE_W'(1) << HUGE_SH;
          side_r[a]  <= SIDE_W'(sel_n) << (HUGE_SH - 16);
        end else begin
          delta_r[a] <= SIDE_W'(q_r);
          side_r[a]  <= SIDE_W'(mul_prod[47:16]);
        end
      end else if (cmd.step && step_ax == 2'(a)) begin
        side_r[a] <= side_r[a] + delta_r[a];
      end
      prod_r[a] <= $signed(dir_r[a]) * $signed(dist_r);
    end

    assign point[a] = sat_dist($signed(WIDE_W'({1'b0, org_r[a]})) + WIDE_W'(prod_r[a] >>> 14));
  end

  // walk control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r      <= AX_X;
      last_r    <= AX_X;
      stepped_r <= 1'b0;
      hit_r     <= 1'b0;
      steps_r   <= '0;
      limit_r   <= 10'd500;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_ch.valid) limit_r <= cfg_ch.step_limit;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + ROW_W'(1);
      if (cmd.ld_in) begin
        ax_r      <= AX_X;
        last_r    <= AX_X;
        stepped_r <= 1'b0;
        hit_r     <= 1'b0;
        steps_r   <= '0;
      end else begin
        if (cmd.ax_inc) ax_r <= ax_r + 2'd1;
        if (cmd.set_hit) hit_r <= 1'b1;
        if (cmd.step) begin
          last_r    <= step_ax;
          stepped_r <= 1'b1;
          steps_r   <= steps_r + 10'd1;
        end
      end
    end
  end

  // occupancy rows: x,y select a row, z selects the bit
  assign vox_row = {GRID_BITS'(vox_r[0]), GRID_BITS'(vox_r[1])};
  assign map_row = {map_r[0][GRID_BITS-1:0], map_r[1][GRID_BITS-1:0]};
  assign vmask   = LINE_W'(1) << GRID_BITS'(vox_r[2]);
  assign we      = cmd.clr | cmd.wb;
  assign waddr   = cmd.clr ? clr_cnt_r : vox_row;
  assign wdata   = cmd.clr ? '0 : (solid_r ? (rdata | vmask) : (rdata & ~vmask));
  assign raddr   = cmd.rd_cast ? map_row : vox_row;

  assign map_in_grid = !map_r[0][MAP_W-1] && (map_r[0] < MAP_W'(GRID_SIZE)) &&
                       !map_r[1][MAP_W-1] && (map_r[1] < MAP_W'(GRID_SIZE)) &&
                       !map_r[2][MAP_W-1] && (map_r[2] < MAP_W'(GRID_SIZE));

  vrd_ram #(.WIDTH(LINE_W), .DEPTH(ROWS)) u_occ (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_cast) begin
      in_grid_r <= map_in_grid;
      zsel_r    <= map_r[2][GRID_BITS-1:0];
    end
    dist_r <= sat_dist($signed({2'b00, side_last}) - $signed({2'b00, delta_last}));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_hit_r <= hit_r;
      if (hit_r) begin
        o_vox_r[0] <= map_r[0][5:0];
        o_vox_r[1] <= map_r[1][5:0];
        o_vox_r[2] <= map_r[2][5:0];
        o_dist_r   <= dist_r;
        o_axis_r   <= stepped_r ? last_r : AX_X;
        o_neg_r    <= stepped_r && !neg_last;
        o_pt_r[0]  <= point[0];
        o_pt_r[1]  <= point[1];
        o_pt_r[2]  <= point[2];
      end else begin
        o_vox_r[0] <= '0;
        o_vox_r[1] <= '0;
        o_vox_r[2] <= '0;
        o_dist_r   <= {1'b0, maxd_r};
        o_axis_r   <= AX_X;
        o_neg_r    <= 1'b0;
        o_pt_r[0]  <= '0;
        o_pt_r[1]  <= '0;
        o_pt_r[2]  <= '0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = o_hit_r;
  assign out_ch.hit_voxel_x     = o_vox_r[0];
  assign out_ch.hit_voxel_y     = o_vox_r[1];
  assign out_ch.hit_voxel_z     = o_vox_r[2];
  assign out_ch.distance        = o_dist_r;
  assign out_ch.normal_axis     = o_axis_r;
  assign out_ch.normal_negative = o_neg_r;
  assign out_ch.point_x         = o_pt_r[0];
  assign out_ch.point_y         = o_pt_r[1];
  assign out_ch.point_z         = o_pt_r[2];

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  // status to controller
  always_comb begin
    sts            = '0;
    sts.in_valid   = in_ch.valid;
    sts.in_op      = in_ch.op;
    sts.clr_last   = &clr_cnt_r;
    sts.wr_in_grid = (11'(vox_r[0]) < 11'(GRID_SIZE)) && (11'(vox_r[1]) < 11'(GRID_SIZE)) &&
                     (11'(vox_r[2]) < 11'(GRID_SIZE));
    sts.ax_last    = (ax_r == AX_Z);
    sts.mag_zero   = (sel_mag == 16'd0);
    sts.div_last   = (div_cnt_r == 5'(DIV_STEPS - 1));
    sts.bound_hit  = stepped_r && (min_all > SIDE_W'(maxd_r));
    sts.steps_done = (steps_r == limit_r);
    sts.cell_solid = in_grid_r && rdata[zsel_r];
    sts.out_free   = !out_valid_r || out_ch.ready;
    sts.stepped    = stepped_r;
  end
endmodule
